// ----- hdl/nqse_pkg.sv -----
// ----------------------------------------------------------------------------
// nqse_pkg
// Shared constants and types for the N-queens solution enumerator:
// board limits, controller-to-datapath commands and datapath status.
// ----------------------------------------------------------------------------
package nqse_pkg;

  localparam int MAX_QUEENS = 8;
  localparam int OUT_COLS   = 8;
  localparam int ROW_W      = (MAX_QUEENS > 1) ? $clog2(MAX_QUEENS) : 1;
  localparam int COL_W      = $clog2(MAX_QUEENS + 1);
  localparam int DIAG_W     = 2 * MAX_QUEENS - 1;
  localparam int DIAG_IDX_W = (DIAG_W > 1) ? $clog2(DIAG_W) : 1;
  localparam int SIZE_W     = 4;
  localparam int OUT_ROW_W  = 4;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_CLEAR   = 3'd2;
  localparam logic [2:0] OP_POP     = 3'd3;
  localparam logic [2:0] OP_PLACE   = 3'd4;
  localparam logic [2:0] OP_ADVANCE = 3'd5;

  typedef struct packed {
    logic [2:0] op;
  } cmd_t;

  typedef struct packed {
    logic col_full;
    logic row_over;
    logic col_zero;
    logic safe;
  } status_t;

endpackage

// ----- hdl/nqse_dp.sv -----
// ----------------------------------------------------------------------------
// nqse_dp
// Search datapath: per-column queen stack, row and diagonal occupancy
// masks, column pointer and trial row. Executes one command per cycle.
// ----------------------------------------------------------------------------
module nqse_dp import nqse_pkg::*; (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [SIZE_W-1:0]                    board_size,
  input  cmd_t                                 cmd,
  input  logic                                 show,
  output status_t                              status,
  output logic [OUT_COLS-1:0][OUT_ROW_W-1:0]   rows
);

  logic [SIZE_W-1:0] size_cfg;
  logic [COL_W-1:0]  size;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  try_row;
  logic [ROW_W-1:0]  queen_row [MAX_QUEENS];
  logic [MAX_QUEENS-1:0] rows_taken;
  logic [DIAG_W-1:0] down_taken;
  logic [DIAG_W-1:0] up_taken;

  logic [COL_W-1:0]      size_sat;
  logic [COL_W-1:0]      pop_col;
  logic [ROW_W-1:0]      pop_row;
  logic [ROW_W-1:0]      tog_row;
  logic [COL_W-1:0]      tog_col;
  logic [COL_W:0]        down_sum;
  logic [COL_W:0]        up_sum;
  logic [COL_W:0]        chk_down_sum;
  logic [COL_W:0]        chk_up_sum;
  logic [DIAG_IDX_W-1:0] tog_down;
  logic [DIAG_IDX_W-1:0] tog_up;
  logic [DIAG_IDX_W-1:0] chk_down;
  logic [DIAG_IDX_W-1:0] chk_up;
  logic                  toggle;

  function automatic logic board_size_zero(input logic [SIZE_W-1:0] v);
    return v == '0;
  endfunction

  always_comb begin
    if (board_size_zero(size_cfg)) begin
      size_sat = COL_W'(1);
    end else if ({1'b0, size_cfg} > (SIZE_W + 1)'(MAX_QUEENS)) begin
      size_sat = COL_W'(MAX_QUEENS);
    end else begin
      size_sat = COL_W'(size_cfg);
    end
  end

  assign pop_col = col - COL_W'(1);
  assign pop_row = queen_row[pop_col[ROW_W-1:0]];

  assign toggle  = (cmd.op == OP_POP) || (cmd.op == OP_PLACE);
  assign tog_row = (cmd.op == OP_POP) ? pop_row : try_row[ROW_W-1:0];
  assign tog_col = (cmd.op == OP_POP) ? pop_col : col;

  assign down_sum = (COL_W + 1)'(tog_row) + (COL_W + 1)'(MAX_QUEENS - 1)
                    - (COL_W + 1)'(tog_col);
  assign up_sum   = (COL_W + 1)'(tog_row) + (COL_W + 1)'(tog_col);
  assign tog_down = down_sum[DIAG_IDX_W-1:0];
  assign tog_up   = up_sum[DIAG_IDX_W-1:0];

  assign chk_down_sum = (COL_W + 1)'(try_row) + (COL_W + 1)'(MAX_QUEENS - 1)
                        - (COL_W + 1)'(col);
  assign chk_up_sum   = (COL_W + 1)'(try_row) + (COL_W + 1)'(col);
  assign chk_down     = chk_down_sum[DIAG_IDX_W-1:0];
  assign chk_up       = chk_up_sum[DIAG_IDX_W-1:0];

  assign status.col_full = col >= size;
  assign status.row_over = try_row >= size;
  assign status.col_zero = col == '0;
  assign status.safe     = !rows_taken[try_row[ROW_W-1:0]] &&
                           !down_taken[chk_down] && !up_taken[chk_up];

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= SIZE_W'(MAX_QUEENS);
    end else if (cfg_wr_en) begin
      size_cfg <= board_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size       <= '0;
      col        <= '0;
      try_row    <= '0;
      rows_taken <= '0;
      down_taken <= '0;
      up_taken   <= '0;
      for (int i = 0; i < MAX_QUEENS; i++) begin
        queen_row[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_START, OP_CLEAR: begin
          if (cmd.op == OP_START) begin
            size <= size_sat;
          end
          col        <= '0;
          try_row    <= '0;
          rows_taken <= '0;
          down_taken <= '0;
          up_taken   <= '0;
          for (int i = 0; i < MAX_QUEENS; i++) begin
            queen_row[i] <= '0;
          end
        end
        OP_POP: begin
          col     <= pop_col;
          try_row <= COL_W'(pop_row) + COL_W'(1);
        end
        OP_PLACE: begin
          queen_row[col[ROW_W-1:0]] <= try_row[ROW_W-1:0];
          col     <= col + COL_W'(1);
          try_row <= '0;
        end
        OP_ADVANCE: begin
          try_row <= try_row + COL_W'(1);
        end
        default: begin
        end
      endcase
      if (toggle) begin
        rows_taken[tog_row] <= ~rows_taken[tog_row];
        down_taken[tog_down] <= ~down_taken[tog_down];
        up_taken[tog_up]     <= ~up_taken[tog_up];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < OUT_COLS; c++) begin
      rows[c] = '0;
      if (c < MAX_QUEENS) begin
        if (show && (COL_W'(c) < size)) begin
          rows[c] = OUT_ROW_W'(queen_row[c % MAX_QUEENS]) + OUT_ROW_W'(1);
        end
      end
    end
  end

endmodule

// ----- hdl/nqse_ctrl.sv -----
// ----------------------------------------------------------------------------
// nqse_ctrl
// Search controller: takes requests, sequences backtracking steps on the
// datapath one per cycle, tracks the search phase and strobes the result.
// ----------------------------------------------------------------------------
module nqse_ctrl import nqse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    restart,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output logic    found
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_HOLDING   = 2'd1;
  localparam logic [1:0] PH_EXHAUSTED = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] phase;
  logic [1:0] phase_next;
  logic       hit;
  logic       hit_next;

  always_comb begin
    state_next = state;
    phase_next = phase;
    hit_next   = hit;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE, ST_REPORT: begin
        state_next = ST_IDLE;
        if (start) begin
          if (restart || (phase == PH_IDLE)) begin
            cmd.op     = OP_START;
            state_next = ST_SEARCH;
          end else if (phase == PH_HOLDING) begin
            cmd.op     = OP_POP;
            state_next = ST_SEARCH;
          end else begin
            hit_next   = 1'b0;
            state_next = ST_REPORT;
          end
        end
      end
      ST_SEARCH: begin
        if (status.col_full) begin
          hit_next   = 1'b1;
          phase_next = PH_HOLDING;
          state_next = ST_REPORT;
        end else if (status.row_over) begin
          if (status.col_zero) begin
            hit_next   = 1'b0;
            phase_next = PH_EXHAUSTED;
            cmd.op     = OP_CLEAR;
            state_next = ST_REPORT;
          end else begin
            cmd.op = OP_POP;
          end
        end else if (status.safe) begin
          cmd.op = OP_PLACE;
        end else begin
          cmd.op = OP_ADVANCE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_IDLE;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      hit   <= hit_next;
    end
  end

  assign busy  = state == ST_SEARCH;
  assign done  = state == ST_REPORT;
  assign found = done && hit;

endmodule

// ----- hdl/n_queens_solution_enumerator.sv -----
// One step (place, advance row, or pop a column) runs per cycle in the datapath.
// A new request is taken only while no search is in progress; start is ignored while busy.
// Without restart, a request made after the search is used up answers in the next cycle with found low.
// Synchronous active-high reset: board_size = 8, search idle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator
// Backtracking N-queens enumerator: each item restarts the search or
// returns the next solution, if any, as 1-based rows per column.
// ----------------------------------------------------------------------------
module n_queens_solution_enumerator import nqse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [SIZE_W-1:0]    board_size,
  input  logic                 start,
  input  logic                 restart,
  output logic                 busy,
  output logic                 done,
  output logic                 found,
  output logic [OUT_ROW_W-1:0] row_col0,
  output logic [OUT_ROW_W-1:0] row_col1,
  output logic [OUT_ROW_W-1:0] row_col2,
  output logic [OUT_ROW_W-1:0] row_col3,
  output logic [OUT_ROW_W-1:0] row_col4,
  output logic [OUT_ROW_W-1:0] row_col5,
  output logic [OUT_ROW_W-1:0] row_col6,
  output logic [OUT_ROW_W-1:0] row_col7
);

  cmd_t    cmd;
  status_t status;
  logic [OUT_COLS-1:0][OUT_ROW_W-1:0] rows;

  nqse_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .restart (restart),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .found   (found)
  );

  nqse_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .board_size (board_size),
    .cmd        (cmd),
    .show       (found),
    .status     (status),
    .rows       (rows)
  );

  assign row_col0 = rows[0];
  assign row_col1 = rows[1];
  assign row_col2 = rows[2];
  assign row_col3 = rows[3];
  assign row_col4 = rows[4];
  assign row_col5 = rows[5];
  assign row_col6 = rows[6];
  assign row_col7 = rows[7];

`ifndef SYNTHESIS
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted item neither searching nor reporting");

  a_found_has_queen: assert property (@(posedge clk) disable iff (rst)
    found |-> row_col0 != '0)
    else $error("solution reported without a queen in column 0");

  a_miss_rows_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> row_col0 == '0 && row_col7 == '0)
    else $error("empty result carries queen rows");

  a_no_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe while search in progress");
`endif

endmodule
